### src/assert_macros.svh
// Assertion macros shared by the palette allocator RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted
`define PCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define PCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCA_ASSERT(label, clk, rst_n, prop, msg)
`define PCA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### src/pca_pkg.sv
// Package for the palette color allocator: types, constants, level tables.
// Used by pca_palette_mem, pca_dist and palette_color_allocator_top.
package pca_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int COLOR_W       = 16;
    localparam int LEVEL_W       = 10;
    localparam int DIST_W        = 14;  // max 4*31^2 + 2*63^2 + 4*31^2 = 15626

    // Scan sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // Candidate flags passed from the distance stage to the compare stage
    typedef struct packed {
        logic valid;
        logic match;
    } t_cand_ctl;

    typedef logic [LEVEL_W-1:0] t_lvl5 [32];
    typedef logic [LEVEL_W-1:0] t_lvl6 [64];

    // 5-bit channel to 0..1000, rounded
    function automatic t_lvl5 build_lvl5();
        t_lvl5 t;
        for (int k = 0; k < 32; k++) begin
            t[k] = LEVEL_W'((k * 1000 + 15) / 31);
        end
        return t;
    endfunction

    // 6-bit channel to 0..1000, rounded
    function automatic t_lvl6 build_lvl6();
        t_lvl6 t;
        for (int k = 0; k < 64; k++) begin
            t[k] = LEVEL_W'((k * 1000 + 31) / 63);
        end
        return t;
    endfunction

    localparam t_lvl5 LVL5 = build_lvl5();
    localparam t_lvl6 LVL6 = build_lvl6();

endpackage

### src/palette_color_allocator_top.sv
// Top level of the palette color allocator: scan sequencer, best/match tracking,
// allocation and result register. Depends on pca_pkg, pca_palette_mem, pca_dist.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | start && !busy       | i_color
//  result  | o_valid (one cycle)  | o_blank o_palette_index o_allocated o_*_level
//
// A blank color gives its result in the cycle after acceptance.
// Any other color reads palette entries 0 .. next_free-1, one per cycle from the
// single memory read port, then drains the distance and compare stages before the
// result is registered. Reset clears next_free to one; only entries below next_free
// are read, so the memory needs no clearing pass. The receiver cannot stall; busy
// drops with the result strobe.
`include "assert_macros.svh"

module palette_color_allocator_top #(
    parameter int PALETTE_DEPTH = pca_pkg::PALETTE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pca_pkg::COLOR_W-1:0]         i_color,
    output logic                                o_valid,
    output logic                                o_blank,
    output logic [7:0]                          o_palette_index,
    output logic                                o_allocated,
    output logic [pca_pkg::LEVEL_W-1:0]         o_red_level,
    output logic [pca_pkg::LEVEL_W-1:0]         o_green_level,
    output logic [pca_pkg::LEVEL_W-1:0]         o_blue_level
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int NW = AW + 1;

    pca_pkg::t_state r_state, n_state;

    logic [pca_pkg::COLOR_W-1:0] r_color;
    logic [AW-1:0]               r_rd_addr;
    logic [NW-1:0]               r_next_free;
    logic                        r_va;
    logic [AW-1:0]               r_idx_a;
    logic [pca_pkg::DIST_W-1:0]  r_best_dist;
    logic [AW-1:0]               r_best_idx;
    logic                        r_found;
    logic [AW-1:0]               r_match_idx;

    logic                        accept;
    logic                        rd_en;
    logic                        last_rd;
    logic                        finish;
    logic                        full;
    logic                        do_alloc;
    logic [NW-1:0]               last_idx;
    logic [pca_pkg::COLOR_W-1:0] rdata;

    pca_pkg::t_cand_ctl          cand_ctl;
    logic [AW-1:0]               cand_idx;
    logic [pca_pkg::DIST_W-1:0]  cand_dist;

    assign busy     = (r_state != pca_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_next_free == NW'(PALETTE_DEPTH));
    assign last_idx = r_next_free - NW'(1);
    assign last_rd  = (r_rd_addr == last_idx[AW-1:0]);
    assign do_alloc = finish && !full && !r_found;

    // Sequencer: next state and strobes
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            pca_pkg::S_IDLE: begin
                if (accept && (i_color != '0)) begin
                    n_state = pca_pkg::S_SCAN;
                end
            end
            pca_pkg::S_SCAN: begin
                rd_en = 1'b1;
                if (last_rd) begin
                    n_state = pca_pkg::S_DRAIN;
                end
            end
            pca_pkg::S_DRAIN: begin
                if (!r_va && !cand_ctl.valid) begin
                    finish  = 1'b1;
                    n_state = pca_pkg::S_IDLE;
                end
            end
            default: n_state = pca_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address and read-valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_va      <= 1'b0;
        end else begin
            r_va <= rd_en;
            if (accept) begin
                r_rd_addr <= '0;
            end else if (rd_en) begin
                r_rd_addr <= r_rd_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_a <= r_rd_addr;
        if (accept) begin
            r_color <= i_color;
        end
    end

    // Palette memory; writes happen only at finish, never during a scan
    pca_palette_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (do_alloc),
        .i_waddr (r_next_free[AW-1:0]),
        .i_wdata (r_color),
        .i_re    (rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (rdata)
    );

    pca_dist #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_idx   (r_idx_a),
        .i_color (r_color),
        .i_entry (rdata),
        .o_ctl   (cand_ctl),
        .o_idx   (cand_idx),
        .o_dist  (cand_dist)
    );

    // Best distance and first exact match; strict compare keeps the lowest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (accept) begin
            r_found <= 1'b0;
        end else if (cand_ctl.valid && cand_ctl.match) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_best_dist <= '1;
        end else if (cand_ctl.valid && (cand_dist < r_best_dist)) begin
            r_best_dist <= cand_dist;
            r_best_idx  <= cand_idx;
        end
        if (cand_ctl.valid && cand_ctl.match && !r_found) begin
            r_match_idx <= cand_idx;
        end
    end

    // Allocation pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= NW'(1);
        end else if (do_alloc) begin
            r_next_free <= r_next_free + NW'(1);
        end
    end

    // Result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (accept && (i_color == '0)) || finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_color == '0)) begin
            o_blank         <= 1'b1;
            o_palette_index <= '0;
            o_allocated     <= 1'b0;
            o_red_level     <= '0;
            o_green_level   <= '0;
            o_blue_level    <= '0;
        end else if (finish) begin
            o_blank       <= 1'b0;
            o_allocated   <= do_alloc;
            o_red_level   <= '0;
            o_green_level <= '0;
            o_blue_level  <= '0;
            if (full) begin
                o_palette_index <= 8'(r_best_idx);
            end else if (r_found) begin
                o_palette_index <= 8'(r_match_idx);
            end else begin
                o_palette_index <= 8'(r_next_free[AW-1:0]);
                o_red_level     <= pca_pkg::LVL5[r_color[15:11]];
                o_green_level   <= pca_pkg::LVL6[r_color[10:5]];
                o_blue_level    <= pca_pkg::LVL5[r_color[4:0]];
            end
        end
    end

    `PCA_ASSERT(a_next_free_range, i_clk, i_rst_n,
        (r_next_free != '0) && (r_next_free <= NW'(PALETTE_DEPTH)),
        "next_free out of range")
    `PCA_ASSERT(a_no_write_in_scan, i_clk, i_rst_n,
        !(do_alloc && (rd_en || r_va || cand_ctl.valid)),
        "palette write overlaps a scan")
    `PCA_ASSERT(a_accept_progress, i_clk, i_rst_n,
        accept |=> (busy || o_valid),
        "accepted item neither scanning nor answered")
    `PCA_ASSERT(a_alloc_not_full, i_clk, i_rst_n,
        do_alloc |=> (r_next_free == $past(r_next_free) + NW'(1)),
        "allocation did not advance next_free")
    `PCA_ASSERT(a_alloc_nonblank, i_clk, i_rst_n,
        (o_valid && o_allocated) |-> !o_blank,
        "blank item reported an allocation")

endmodule

### src/pca_palette_mem.sv
// Palette storage: one write port, one read port, registered read data.
// Depends on pca_pkg for the color width.
module pca_palette_mem #(
    parameter int DEPTH = pca_pkg::PALETTE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pca_pkg::COLOR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [pca_pkg::COLOR_W-1:0] o_rdata
);

    logic [pca_pkg::COLOR_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/pca_dist.sv
// Distance stage: weighted squared distance and exact match for one entry.
// Depends on pca_pkg (t_cand_ctl, DIST_W, COLOR_W).
module pca_dist #(
    parameter int AW = $clog2(pca_pkg::PALETTE_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [AW-1:0]               i_idx,
    input  logic [pca_pkg::COLOR_W-1:0] i_color,
    input  logic [pca_pkg::COLOR_W-1:0] i_entry,
    output pca_pkg::t_cand_ctl          o_ctl,
    output logic [AW-1:0]               o_idx,
    output logic [pca_pkg::DIST_W-1:0]  o_dist
);

    logic [pca_pkg::COLOR_W-1:0] entry;
    logic [4:0]  dr, db;
    logic [5:0]  dg;
    logic [9:0]  sr, sb;
    logic [11:0] sg;
    logic [pca_pkg::DIST_W-1:0] dist_sum;

    // Entry 0 is black and never written: force it here
    assign entry = (i_idx == '0) ? '0 : i_entry;

    // Absolute channel differences
    assign dr = (i_color[15:11] > entry[15:11]) ? i_color[15:11] - entry[15:11]
                                                : entry[15:11] - i_color[15:11];
    assign dg = (i_color[10:5] > entry[10:5]) ? i_color[10:5] - entry[10:5]
                                              : entry[10:5] - i_color[10:5];
    assign db = (i_color[4:0] > entry[4:0]) ? i_color[4:0] - entry[4:0]
                                            : entry[4:0] - i_color[4:0];

    // Squares and the 4,2,4 weighted sum
    assign sr       = 10'(dr * dr);
    assign sg       = 12'(dg * dg);
    assign sb       = 10'(db * db);
    assign dist_sum = {2'b00, sr, 2'b00} + {1'b0, sg, 1'b0} + {2'b00, sb, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl.valid <= i_valid;
            o_ctl.match <= i_valid && (entry == i_color);
        end
    end

    always_ff @(posedge i_clk) begin
        o_idx  <= i_idx;
        o_dist <= dist_sum;
    end

endmodule
